// File: hw/rtl/ssfb_pkg.sv
`default_nettype none

package ssfb_pkg;

	// Storage and frame layout fixed by the display driver's register map.
	localparam int SLOT_COUNT   = 8;
	localparam int SETUP_WORDS  = 5;
	localparam int FRAME_WORDS  = SETUP_WORDS + SLOT_COUNT;
	localparam int QUEUE_DEPTH  = 2;

	localparam int DIGIT_SLOTS_DEFAULT = 8;
	localparam int MAX_CHARS_DEFAULT   = 10;

	localparam logic [7:0] POINT_BIT = 8'h80;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	localparam logic [3:0] LAST_POSITION = 4'(FRAME_WORDS - 1);
	localparam logic [3:0] FIRST_SLOT_POSITION = 4'(SETUP_WORDS);

	// Configuration register indexes.
	localparam logic [2:0] REG_SHUTDOWN    = 3'd0;
	localparam logic [2:0] REG_TEST        = 3'd1;
	localparam logic [2:0] REG_SCAN_LIMIT  = 3'd2;
	localparam logic [2:0] REG_INTENSITY   = 3'd3;
	localparam logic [2:0] REG_DECODE      = 3'd4;
	localparam logic [2:0] REG_DIGIT_LIMIT = 3'd5;

	localparam logic [15:0] SHUTDOWN_RESET    = 16'd3073;
	localparam logic [15:0] TEST_RESET        = 16'd3840;
	localparam logic [15:0] SCAN_LIMIT_RESET  = 16'd2823;
	localparam logic [15:0] INTENSITY_RESET   = 16'd2568;
	localparam logic [15:0] DECODE_RESET      = 16'd2304;
	localparam logic [3:0]  DIGIT_LIMIT_RESET = 4'd8;

	typedef logic [SETUP_WORDS-1:0][15:0] setup_words_t;
	typedef logic [SLOT_COUNT-1:0][7:0]   slot_segs_t;

	// One finished string, handed from the front to the frame emitter.
	typedef struct packed {
		logic [3:0] tag;
		logic [3:0] filled;
		slot_segs_t segs;
	} frame_t;

	typedef struct packed {
		logic   valid;
		frame_t frame;
	} frame_push_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] code;
	} seg_lookup_t;

	// Fixed segment patterns, bit 6 is segment a down to bit 0 segment g.
	function automatic seg_lookup_t seg_code(input logic [7:0] c);
		seg_lookup_t r;
		r.ok = 1'b1;
		unique case (c)
			8'h30: r.code = 8'h7E;
			8'h31: r.code = 8'h30;
			8'h32: r.code = 8'h6D;
			8'h33: r.code = 8'h79;
			8'h34: r.code = 8'h33;
			8'h35: r.code = 8'h5B;
			8'h36: r.code = 8'h5F;
			8'h37: r.code = 8'h70;
			8'h38: r.code = 8'h7F;
			8'h39: r.code = 8'h7B;
			8'h41: r.code = 8'h77; // A
			8'h62: r.code = 8'h1F; // b
			8'h43: r.code = 8'h4E; // C
			8'h64: r.code = 8'h3D; // d
			8'h45: r.code = 8'h4F; // E
			8'h46: r.code = 8'h47; // F
			8'h68: r.code = 8'h17; // h
			8'h49: r.code = 8'h30; // I
			8'h69: r.code = 8'h10; // i
			8'h4A: r.code = 8'h3C; // J
			8'h4C: r.code = 8'h0E; // L
			8'h4F: r.code = 8'h7E; // O
			8'h50: r.code = 8'h67; // P
			8'h72: r.code = 8'h05; // r
			8'h74: r.code = 8'h0F; // t
			8'h55: r.code = 8'h3E; // U
			8'h75: r.code = 8'h1C; // u
			8'h2D: r.code = 8'h01; // minus
			8'h5F: r.code = 8'h08; // underscore
			8'h20: r.code = 8'h00; // space
			default: begin
				r.ok   = 1'b0;
				r.code = 8'h00;
			end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ssfb_front.sv
`default_nettype none

module ssfb_front import ssfb_pkg::*; #(
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEFAULT,
	parameter int MAX_CHARS   = MAX_CHARS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  character,
	input  logic        first_char,
	input  logic        last_char,
	input  logic [3:0]  indicator_index,
	input  logic [3:0]  digit_limit,
	input  logic        queue_full,
	output frame_push_t push
);

	localparam int FILL_W = $clog2(DIGIT_SLOTS + 1);
	localparam int CHAR_W = $clog2(MAX_CHARS + 1);

	logic [7:0]        segs_q [DIGIT_SLOTS];
	logic [FILL_W-1:0] filled_q;
	logic [CHAR_W-1:0] chars_q;
	logic              prev_dot_q;
	logic              stopped_q;

	logic [7:0]        base_segs [DIGIT_SLOTS];
	logic [7:0]        next_segs [DIGIT_SLOTS];
	logic [FILL_W-1:0] base_filled, next_filled;
	logic [CHAR_W-1:0] base_chars, next_chars;
	logic              base_prev, next_prev;
	logic              base_stop, next_stop;
	logic              accept, take, is_dot, dot_opens, need_open, can_open, mark;
	logic [3:0]        limit;
	logic [7:0]        open_code;
	seg_lookup_t       lookup;

	assign char_stall = queue_full;
	assign accept     = char_valid && !char_stall;

	// A first character sees a cleared string.
	always_comb begin
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			base_segs[i] = first_char ? 8'h00 : segs_q[i];
		end
		base_filled = first_char ? '0 : filled_q;
		base_chars  = first_char ? '0 : chars_q;
		base_prev   = first_char ? 1'b0 : prev_dot_q;
		base_stop   = first_char ? 1'b0 : stopped_q;
	end

	assign limit     = (digit_limit > 4'(DIGIT_SLOTS)) ? 4'(DIGIT_SLOTS) : digit_limit;
	assign lookup    = seg_code(character);
	assign is_dot    = (character == CHAR_DOT);
	assign take      = !base_stop && (base_chars < CHAR_W'(MAX_CHARS));
	assign dot_opens = (base_filled == '0) || base_prev;
	assign need_open = take && (is_dot ? dot_opens : lookup.ok);
	assign mark      = take && is_dot && !dot_opens;
	assign can_open  = 4'(base_filled) < limit;
	assign open_code = is_dot ? POINT_BIT : lookup.code;

	always_comb begin
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			next_segs[i] = base_segs[i];
			if (need_open && can_open && (FILL_W'(i) == base_filled)) begin
				next_segs[i] = open_code;
			end
			if (mark && (FILL_W'(i + 1) == base_filled)) begin
				next_segs[i] = base_segs[i] | POINT_BIT;
			end
		end
		next_filled = base_filled + FILL_W'(need_open && can_open);
		next_stop   = base_stop || (need_open && !can_open);
		next_chars  = base_chars + CHAR_W'(take);
		next_prev   = take ? is_dot : base_prev;
	end

	always_comb begin
		push.valid        = accept && last_char;
		push.frame.tag    = indicator_index;
		push.frame.filled = 4'(next_filled);
		for (int i = 0; i < SLOT_COUNT; i++) begin
			push.frame.segs[i] = (i < DIGIT_SLOTS) ? next_segs[i] : 8'h00;
		end
	end

	// The string state is cleared once its frame is queued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q   <= '0;
			chars_q    <= '0;
			prev_dot_q <= 1'b0;
			stopped_q  <= 1'b0;
			for (int i = 0; i < DIGIT_SLOTS; i++) begin
				segs_q[i] <= 8'h00;
			end
		end else if (accept) begin
			if (last_char) begin
				filled_q   <= '0;
				chars_q    <= '0;
				prev_dot_q <= 1'b0;
				stopped_q  <= 1'b0;
				for (int i = 0; i < DIGIT_SLOTS; i++) begin
					segs_q[i] <= 8'h00;
				end
			end else begin
				filled_q   <= next_filled;
				chars_q    <= next_chars;
				prev_dot_q <= next_prev;
				stopped_q  <= next_stop;
				for (int i = 0; i < DIGIT_SLOTS; i++) begin
					segs_q[i] <= next_segs[i];
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ssfb_queue.sv
`default_nettype none

module ssfb_queue import ssfb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  frame_push_t push,
	input  logic        pop,
	output frame_t      head,
	output logic        full,
	output logic        empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	frame_t            store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push.valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			store_q[wr_ptr_q] <= push.frame;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/ssfb_back.sv
`default_nettype none

module ssfb_back import ssfb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  setup_words_t setup_words,
	input  frame_t       head,
	input  logic         empty,
	output logic         pop,
	output logic         word_valid,
	input  logic         word_stall,
	output logic [3:0]   indicator_tag,
	output logic [3:0]   word_position,
	output logic [15:0]  frame_word,
	output logic [3:0]   words_used,
	output logic         final_word
);

	logic [3:0]  pos_q;
	logic        valid_q;
	logic        advance, load;
	logic [3:0]  slot_pos;
	logic [7:0]  addr_byte;
	logic [15:0] word;

	assign advance = !valid_q || !word_stall;
	assign load    = advance && !empty;
	assign pop     = load && (pos_q == LAST_POSITION);

	assign slot_pos  = pos_q - FIRST_SLOT_POSITION;
	assign addr_byte = 8'(slot_pos) + 8'd1;

	always_comb begin
		if (pos_q < FIRST_SLOT_POSITION) begin
			word = setup_words[pos_q[2:0]];
		end else begin
			word = {addr_byte, head.segs[slot_pos[2:0]]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= !empty;
			if (!empty) begin
				pos_q <= (pos_q == LAST_POSITION) ? '0 : pos_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			indicator_tag <= head.tag;
			word_position <= pos_q;
			frame_word    <= word;
			words_used    <= 4'(SETUP_WORDS) + head.filled;
			final_word    <= (pos_q == LAST_POSITION);
		end
	end

	assign word_valid = valid_q;

endmodule

`default_nettype wire

// File: hw/rtl/seven_segment_frame_builder.sv
// Channel   Direction  Handshake               Beat carries
// char      in         char_valid/char_stall   character, first_char, last_char,
//                                              indicator_index
// word      out        word_valid/word_stall   indicator_tag, word_position,
//                                              frame_word, words_used, final_word
// cfg       in         cfg_valid/cfg_ready     cfg_index, cfg_data
//
// A character beat is taken every unstalled cycle; the string state is registered.
// A last character queues a frame, emitted as 13 beats, one per unstalled cycle.
// Two frames can wait in the queue; char_stall rises only while it is full.
// Reset clears the string state, the queue and the emitter, and loads the
// configuration registers with their defaults. cfg_ready is always high.
`default_nettype none

module seven_segment_frame_builder import ssfb_pkg::*; #(
	parameter int DIGIT_SLOTS = DIGIT_SLOTS_DEFAULT,
	parameter int MAX_CHARS   = MAX_CHARS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  character,
	input  logic        first_char,
	input  logic        last_char,
	input  logic [3:0]  indicator_index,
	output logic        word_valid,
	input  logic        word_stall,
	output logic [3:0]  indicator_tag,
	output logic [3:0]  word_position,
	output logic [15:0] frame_word,
	output logic [3:0]  words_used,
	output logic        final_word,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	setup_words_t setup_q;
	logic [3:0]   digit_limit_q;
	frame_push_t  push;
	frame_t       head;
	logic         full, empty, pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q[REG_SHUTDOWN]   <= SHUTDOWN_RESET;
			setup_q[REG_TEST]       <= TEST_RESET;
			setup_q[REG_SCAN_LIMIT] <= SCAN_LIMIT_RESET;
			setup_q[REG_INTENSITY]  <= INTENSITY_RESET;
			setup_q[REG_DECODE]     <= DECODE_RESET;
			digit_limit_q           <= DIGIT_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index) inside
				REG_SHUTDOWN, REG_TEST, REG_SCAN_LIMIT, REG_INTENSITY, REG_DECODE: begin
					setup_q[cfg_index] <= cfg_data;
				end
				REG_DIGIT_LIMIT: begin
					digit_limit_q <= cfg_data[3:0];
				end
				default: begin
				end
			endcase
		end
	end

	ssfb_front #(
		.DIGIT_SLOTS (DIGIT_SLOTS),
		.MAX_CHARS   (MAX_CHARS)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.character       (character),
		.first_char      (first_char),
		.last_char       (last_char),
		.indicator_index (indicator_index),
		.digit_limit     (digit_limit_q),
		.queue_full      (full),
		.push            (push)
	);

	ssfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	ssfb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.setup_words   (setup_q),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.word_valid    (word_valid),
		.word_stall    (word_stall),
		.indicator_tag (indicator_tag),
		.word_position (word_position),
		.frame_word    (frame_word),
		.words_used    (words_used),
		.final_word    (final_word)
	);

endmodule

`default_nettype wire

// File: hw/rtl/ssfb_checker.sv
`default_nettype none

module ssfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        word_valid,
	input logic        word_stall,
	input logic [3:0]  indicator_tag,
	input logic [3:0]  word_position,
	input logic [15:0] frame_word,
	input logic [3:0]  words_used,
	input logic        final_word
);

	// A stalled beat holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_stall |=> word_valid && $stable(frame_word)
			&& $stable(word_position))
		else $error("stalled word beat changed");

	// The end marker sits on the last position and only there.
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> (final_word == (word_position == 4'd12)))
		else $error("final_word does not match word_position");

	// Inside a frame the beats follow back to back in order.
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_stall && !final_word |=> word_valid
			&& (word_position == $past(word_position) + 4'd1))
		else $error("frame beats out of sequence");

	// Tag and word count stay the same across one frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && !word_stall && !final_word |=> $stable(indicator_tag)
			&& $stable(words_used))
		else $error("frame header fields changed within a frame");

endmodule

bind seven_segment_frame_builder ssfb_checker u_ssfb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.word_valid    (word_valid),
	.word_stall    (word_stall),
	.indicator_tag (indicator_tag),
	.word_position (word_position),
	.frame_word    (frame_word),
	.words_used    (words_used),
	.final_word    (final_word)
);

`default_nettype wire

// File: bench/seven_segment_frame_builder_test.sv
`timescale 1ns / 100ps

module seven_segment_frame_builder_test;
	import ssfb_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int CONFIG_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 20;

	localparam logic [2:0] REG_ORDER [6] = '{REG_SHUTDOWN, REG_TEST, REG_SCAN_LIMIT,
		REG_INTENSITY, REG_DECODE, REG_DIGIT_LIMIT};

	// One word of an emitted frame, in port order.
	typedef struct packed {
		logic [3:0]  tag;
		logic [3:0]  pos;
		logic [15:0] word;
		logic [3:0]  used;
		logic        fin;
	} word_beat_t;

	// Directed character; when typed is set, words_used and the first slot word
	// of the frame it closes are taken from the row instead of the predictor.
	typedef struct packed {
		logic [7:0]  ch;
		logic        fst;
		logic        lst;
		logic [3:0]  idx;
		logic        typed;
		logic [3:0]  used;
		logic [15:0] slot0;
	} char_row_t;

	localparam char_row_t DIRECTED [23] = '{
		'{"8",   1'b1, 1'b1, 4'd0,  1'b1, 4'd6,  16'h017F},
		'{8'h00, 1'b1, 1'b1, 4'd15, 1'b1, 4'd5,  16'h0100},
		'{8'hFF, 1'b1, 1'b1, 4'd5,  1'b1, 4'd5,  16'h0100},
		'{".",   1'b1, 1'b1, 4'd3,  1'b1, 4'd6,  16'h0180},
		'{".",   1'b1, 1'b0, 4'd10, 1'b0, 4'd0,  16'h0000},
		'{".",   1'b0, 1'b1, 4'd10, 1'b1, 4'd7,  16'h0180},
		'{"1",   1'b1, 1'b0, 4'd1,  1'b0, 4'd0,  16'h0000},
		'{".",   1'b0, 1'b0, 4'd1,  1'b0, 4'd0,  16'h0000},
		'{"2",   1'b0, 1'b1, 4'd12, 1'b1, 4'd7,  16'h01B0},
		'{"1",   1'b1, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{".",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{"1",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{".",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{"1",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{".",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{"1",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{".",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{"1",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{".",   1'b0, 1'b0, 4'd2,  1'b0, 4'd0,  16'h0000},
		'{"2",   1'b0, 1'b1, 4'd14, 1'b1, 4'd10, 16'h01B0},
		'{"-",   1'b0, 1'b1, 4'd7,  1'b1, 4'd6,  16'h0101},
		'{"_",   1'b1, 1'b0, 4'd9,  1'b0, 4'd0,  16'h0000},
		'{" ",   1'b0, 1'b1, 4'd9,  1'b1, 4'd7,  16'h0108}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        char_valid = 1'b0;
	logic        char_stall;
	logic [7:0]  character = 8'h00;
	logic        first_char = 1'b0;
	logic        last_char = 1'b0;
	logic [3:0]  indicator_index = 4'd0;
	logic        word_valid;
	logic        word_stall = 1'b0;
	logic [3:0]  indicator_tag;
	logic [3:0]  word_position;
	logic [15:0] frame_word;
	logic [3:0]  words_used;
	logic        final_word;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_SHUTDOWN;
	logic [15:0] cfg_data = 16'h0000;

	// Predictor copy of the configuration and the string being built.
	logic [15:0] setup_regs [SETUP_WORDS];
	logic [3:0]  digit_cap;
	logic [7:0]  lit_slots [SLOT_COUNT];
	int          lit_count;
	int          char_count;
	logic        after_dot;
	logic        halted;

	word_beat_t  pending_words [$];

	bit  calm = 1'b0;
	int  stall_left = 0;
	int  mismatches = 0;
	int  words_checked = 0;
	int  frames_seen = 0;
	int  chars_sent = 0;
	int  cfg_writes = 0;
	string glyph_set = "0123456789AbCdEFhIiJLOPrtUu-_ ";

	seven_segment_frame_builder u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.char_valid      (char_valid),
		.char_stall      (char_stall),
		.character       (character),
		.first_char      (first_char),
		.last_char       (last_char),
		.indicator_index (indicator_index),
		.word_valid      (word_valid),
		.word_stall      (word_stall),
		.indicator_tag   (indicator_tag),
		.word_position   (word_position),
		.frame_word      (frame_word),
		.words_used      (words_used),
		.final_word      (final_word),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic logic glyph_of(input logic [7:0] c, output logic [7:0] seg);
		logic hit;
		hit = 1'b1;
		seg = 8'h00;
		case (c)
			"0": seg = 8'h7E;
			"1": seg = 8'h30;
			"2": seg = 8'h6D;
			"3": seg = 8'h79;
			"4": seg = 8'h33;
			"5": seg = 8'h5B;
			"6": seg = 8'h5F;
			"7": seg = 8'h70;
			"8": seg = 8'h7F;
			"9": seg = 8'h7B;
			"A": seg = 8'h77;
			"b": seg = 8'h1F;
			"C": seg = 8'h4E;
			"d": seg = 8'h3D;
			"E": seg = 8'h4F;
			"F": seg = 8'h47;
			"h": seg = 8'h17;
			"I": seg = 8'h30;
			"i": seg = 8'h10;
			"J": seg = 8'h3C;
			"L": seg = 8'h0E;
			"O": seg = 8'h7E;
			"P": seg = 8'h67;
			"r": seg = 8'h05;
			"t": seg = 8'h0F;
			"U": seg = 8'h3E;
			"u": seg = 8'h1C;
			"-": seg = 8'h01;
			"_": seg = 8'h08;
			" ": seg = 8'h00;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	function automatic void clear_string();
		foreach (lit_slots[s]) lit_slots[s] = 8'h00;
		lit_count = 0;
		char_count = 0;
		after_dot = 1'b0;
		halted = 1'b0;
	endfunction

	// Once the slot limit is hit the rest of the string is dropped.
	function automatic void open_slot(input logic [7:0] seg);
		int cap;
		cap = digit_cap;
		if (cap > DIGIT_SLOTS_DEFAULT) cap = DIGIT_SLOTS_DEFAULT;
		if (cap > SLOT_COUNT) cap = SLOT_COUNT;
		if (lit_count >= cap) begin
			halted = 1'b1;
		end else begin
			lit_slots[lit_count] = seg;
			lit_count++;
		end
	endfunction

	function automatic void encode_character(input logic [7:0] ch, input logic fst,
		input logic lst, input logic [3:0] idx);
		logic [7:0] seg;
		word_beat_t beat;
		if (fst) clear_string();
		if (!halted && char_count < MAX_CHARS_DEFAULT) begin
			char_count++;
			if (ch == CHAR_DOT) begin
				// A dot marks the prior slot unless there is none or a dot came just before.
				if (lit_count == 0 || after_dot) open_slot(POINT_BIT);
				else lit_slots[lit_count - 1] = lit_slots[lit_count - 1] | POINT_BIT;
				after_dot = 1'b1;
			end else begin
				after_dot = 1'b0;
				if (glyph_of(ch, seg)) open_slot(seg);
			end
		end
		if (lst) begin
			for (int k = 0; k < FRAME_WORDS; k++) begin
				beat.tag = idx;
				beat.pos = 4'(k);
				if (k < SETUP_WORDS) beat.word = setup_regs[k];
				else beat.word = {8'(k - SETUP_WORDS + 1), lit_slots[k - SETUP_WORDS]};
				beat.used = 4'(SETUP_WORDS + lit_count);
				beat.fin = (k == FRAME_WORDS - 1);
				pending_words.push_back(beat);
			end
			clear_string();
		end
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return glyph_set[$urandom_range(0, glyph_set.len() - 1)];
		if (r < 80) return CHAR_DOT;
		if (r < 92) return 8'($urandom);
		if (r < 96) return 8'h00;
		return 8'hFF;
	endfunction

	task automatic report_mismatch(input string what, input word_beat_t want,
		input word_beat_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%0t %s: expected tag %0d pos %0d word %h used %0d last %0b, ",
				$time, what, want.tag, want.pos, want.word, want.used, want.fin);
			$display("got tag %0d pos %0d word %h used %0d last %0b",
				got.tag, got.pos, got.word, got.used, got.fin);
		end
	endtask

	// Valid stays high across back-to-back beats; only the payload changes.
	task automatic send_char(input logic [7:0] ch, input logic fst, input logic lst,
		input logic [3:0] idx);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			char_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		char_valid <= 1'b1;
		character <= ch;
		first_char <= fst;
		last_char <= lst;
		indicator_index <= idx;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		chars_sent++;
		encode_character(ch, fst, lst, idx);
	endtask

	task automatic wait_drained();
		char_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(input int phase);
		logic [15:0] data;
		logic [3:0] cap;
		case (phase)
			0: cap = 4'd1;
			1: cap = 4'd8;
			2: cap = 4'd0;
			3: cap = 4'd15;
			4: cap = 4'($urandom_range(2, 7));
			default: cap = 4'($urandom_range(0, 15));
		endcase
		cfg_valid <= 1'b1;
		for (int i = 0; i < 6; i++) begin
			if (REG_ORDER[i] == REG_DIGIT_LIMIT) data = {12'($urandom), cap};
			else if (phase == 0) data = 16'h0000;
			else if (phase == 1) data = 16'hFFFF;
			else data = 16'($urandom);
			cfg_index <= REG_ORDER[i];
			cfg_data <= data;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			cfg_writes++;
			if (REG_ORDER[i] == REG_DIGIT_LIMIT) digit_cap = data[3:0];
			else setup_regs[REG_ORDER[i]] = data;
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly short strings that open with first_char; a few long ones run into
	// the character and slot limits, and a stray first_char restarts mid-string.
	task automatic run_strings(input int n);
		int sent;
		int len;
		logic fst;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 4) != 0) len = $urandom_range(1, 6);
			else len = $urandom_range(7, 14);
			for (int p = 0; p < len; p++) begin
				if (p == 0) fst = ($urandom_range(0, 9) != 0);
				else fst = ($urandom_range(0, 24) == 0);
				send_char(pick_char(), fst, p == len - 1, 4'($urandom));
			end
			sent += len;
		end
	endtask

	always @(posedge clk) begin : stall_gen
		int r;
		if (calm) begin
			word_stall <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 50) begin
				word_stall <= 1'b0;
				stall_left <= $urandom_range(0, 6);
			end else if (r < 92) begin
				word_stall <= 1'b1;
				stall_left <= $urandom_range(0, 2);
			end else begin
				word_stall <= 1'b1;
				stall_left <= $urandom_range(8, 40);
			end
		end
	end

	always @(posedge clk) begin : word_check
		word_beat_t got;
		word_beat_t want;
		if (arst_n && word_valid && !word_stall) begin
			got = '{indicator_tag, word_position, frame_word, words_used, final_word};
			words_checked++;
			if (final_word) frames_seen++;
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected beat", '0, got);
			end else begin
				want = pending_words.pop_front();
				if (want != got) report_mismatch("frame word mismatch", want, got);
			end
		end
	end

	initial begin
		word_beat_t beat;
		int j;
		setup_regs = '{SHUTDOWN_RESET, TEST_RESET, SCAN_LIMIT_RESET, INTENSITY_RESET,
			DECODE_RESET};
		digit_cap = DIGIT_LIMIT_RESET;
		clear_string();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED); i++) begin
			send_char(DIRECTED[i].ch, DIRECTED[i].fst, DIRECTED[i].lst, DIRECTED[i].idx);
			if (DIRECTED[i].typed) begin
				for (int k = 0; k < FRAME_WORDS; k++) begin
					j = pending_words.size() - FRAME_WORDS + k;
					beat = pending_words[j];
					beat.used = DIRECTED[i].used;
					if (k == SETUP_WORDS) beat.word = DIRECTED[i].slot0;
					pending_words[j] = beat;
				end
			end
		end
		wait_drained();

		// Each setting starts from an empty pipe, so the sender holds off here.
		for (int ph = 0; ph < CONFIG_PHASES; ph++) begin
			calm = (ph == 3);
			load_config(ph);
			run_strings(ITEMS_PER_PHASE);
			wait_drained();
		end

		$display("Sent %0d characters over %0d register writes and %0d settings;",
			chars_sent, cfg_writes, CONFIG_PHASES + 1);
		$display("checked %0d frame words in %0d frames, %0d mismatches.",
			words_checked, frames_seen, mismatches);
		if (mismatches == 0 && pending_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
